// ----- src/fnote_pkg.sv -----
// ----------------------------------------------------------------------------
// fnote_pkg: shared types, constants and pitch table
// Word types for both channels, the configuration register codes, the
// octave-8 pitch table and the note pitch function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnote_pkg;

  localparam int MEAS_W  = 24;
  localparam int FREQ_W  = 28;
  localparam int PITCH_W = 20;
  localparam int QUOT_W  = 15;
  localparam int REM_W   = QUOT_W + PITCH_W;
  localparam int NUM_W   = FREQ_W + 14;
  localparam int LEVEL_W = 15;
  localparam int NOTES   = 108;
  localparam int OCTS    = 9;
  localparam int SEMIS   = 12;
  localparam int CFG_INDEX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE_RESET   = 15'd50;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO_RESET   = 15'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE_RESET = 15'd200;
  localparam logic [15:0]        MIS_MAX           = 16'd32767;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MARK_ONE   = 2'd0,
    CFG_MARK_TWO   = 2'd1,
    CFG_MARK_THREE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [MEAS_W-1:0] measured_frequency;
    logic              tenths_mode;
  } meas_word_t;

  typedef struct packed {
    logic [FREQ_W-1:0]  scaled_frequency;
    logic [3:0]         octave;
    logic [3:0]         note_in_octave;
    logic [PITCH_W-1:0] matched_pitch;
    logic signed [15:0] mismatch;
    logic               sharp;
    logic [1:0]         mark_count;
  } note_word_t;

  // Fields that ride along beside the divider.
  typedef struct packed {
    logic [FREQ_W-1:0]  scaled;
    logic [3:0]         octave;
    logic [3:0]         semi;
    logic [PITCH_W-1:0] pitch;
    logic               neg;
    logic               sat;
  } side_t;

  function automatic logic [PITCH_W-1:0] top_pitch(input logic [3:0] semi);
    logic [PITCH_W-1:0] p;
    case (semi)
      4'd0:    p = 20'd418601;
      4'd1:    p = 20'd443492;
      4'd2:    p = 20'd469864;
      4'd3:    p = 20'd497803;
      4'd4:    p = 20'd527404;
      4'd5:    p = 20'd558765;
      4'd6:    p = 20'd591991;
      4'd7:    p = 20'd627193;
      4'd8:    p = 20'd664488;
      4'd9:    p = 20'd704000;
      4'd10:   p = 20'd745862;
      4'd11:   p = 20'd790213;
      default: p = 20'd790213;
    endcase
    return p;
  endfunction

  // Pitch of a note in hundredths of a hertz; octave is 0 to 8.
  function automatic logic [PITCH_W-1:0] pitch_of(input logic [3:0] octave,
                                                  input logic [3:0] semi);
    logic [3:0] sh;
    sh = 4'd8 - octave;
    return top_pitch(semi) >> sh;
  endfunction

endpackage

// ----- src/frequency_to_musical_note.sv -----
// ----------------------------------------------------------------------------
// frequency_to_musical_note: nearest equal-tempered note for a frequency
// Each measurement word is scaled to hundredths of a hertz (times ten in
// tenths mode) and matched to the nearest of the 108 notes C0 to B8; a tie
// between two notes goes to the lower one. The result word gives the octave,
// the note within the octave, the note's table pitch, the signed deviation in
// basis points (truncated toward zero, held at 32767 at the top), a sharp
// flag and a count of 0 to 3 deviation marks set by three threshold
// registers. The block takes one word every cycle while meas_stall is low
// and returns each result through six stages of scaling, note search, nearest
// choice, deviation product and range check, fifteen divider stages that
// each settle one quotient bit, and one output register. Every stage holds
// its word under stall and fills a bubble in front of it, so the input keeps
// moving while a result waits at the output until the pipeline is full.
// Threshold registers are written through the configuration channel, which
// is always ready; an index beyond the third register is ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frequency_to_musical_note import fnote_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   meas_valid,
  output logic                   meas_stall,
  input  meas_word_t             meas,
  output logic                   note_valid,
  input  logic                   note_stall,
  output note_word_t             note,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data
);

  // Threshold registers.
  logic [LEVEL_W-1:0] level_one, level_two, level_three;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_one   <= LEVEL_ONE_RESET;
      level_two   <= LEVEL_TWO_RESET;
      level_three <= LEVEL_THREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MARK_ONE:   level_one   <= cfg_data;
        CFG_MARK_TWO:   level_two   <= cfg_data;
        CFG_MARK_THREE: level_three <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Stage valid bits and the advance chain. A stage loads when it is empty
  // or when the stage after it is loading.
  logic v1, v2, v3, v4, v5, v6;
  logic go1, go2, go3, go4, go5, go6, go_out;
  logic div_stall, div_valid;

  assign go_out = !note_valid || !note_stall;
  assign go6    = !v6 || !div_stall;
  assign go5    = !v5 || go6;
  assign go4    = !v4 || go5;
  assign go3    = !v3 || go4;
  assign go2    = !v2 || go3;
  assign go1    = !v1 || go2;
  assign meas_stall = !go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (go1) begin
        v1 <= meas_valid;
      end
      if (go2) begin
        v2 <= v1;
      end
      if (go3) begin
        v3 <= v2;
      end
      if (go4) begin
        v4 <= v3;
      end
      if (go5) begin
        v5 <= v4;
      end
      if (go6) begin
        v6 <= v5;
      end
    end
  end

  // Stage 1: scale to hundredths of a hertz; times ten is 8x plus 2x.
  logic [FREQ_W-1:0] f1, scaled_next;
  logic [FREQ_W-1:0] meas_wide;

  assign meas_wide   = {{(FREQ_W-MEAS_W){1'b0}}, meas.measured_frequency};
  assign scaled_next = meas.tenths_mode ? (meas_wide << 3) + (meas_wide << 1)
                                        : meas_wide;

  always_ff @(posedge clk) begin
    if (go1) begin
      f1 <= scaled_next;
    end
  end

  // Stage 2: compare the frequency against every note pitch. The pitches
  // rise with the note number, so the result is a thermometer code.
  logic [NOTES-1:0]  gt2, gt_next;
  logic [FREQ_W-1:0] f2;

  always_comb begin
    for (int n = 0; n < NOTES; n++) begin
      gt_next[n] = f1 > {{(FREQ_W-PITCH_W){1'b0}},
                         pitch_of(4'(n / SEMIS), 4'(n % SEMIS))};
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      gt2 <= gt_next;
      f2  <= f1;
    end
  end

  // Stage 3: the lower note is the last one below the frequency. Its octave
  // is the last octave whose C is below; its semitone is the count of
  // notes below within that octave, less one.
  logic [3:0]        lo_oct3, lo_semi3, oct_next, semi_next;
  logic              found3;
  logic [FREQ_W-1:0] f3;
  logic [SEMIS-1:0]  row;
  logic [3:0]        row_count;

  always_comb begin
    oct_next  = '0;
    row       = '0;
    row_count = '0;
    for (int k = 0; k < OCTS; k++) begin
      if (gt2[k*SEMIS]) begin
        oct_next = 4'(k);
        row      = gt2[k*SEMIS +: SEMIS];
      end
    end
    for (int s = 0; s < SEMIS; s++) begin
      row_count = row_count + {3'b0, row[s]};
    end
    semi_next = gt2[0] ? row_count - 4'd1 : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      lo_oct3  <= oct_next;
      lo_semi3 <= semi_next;
      found3   <= gt2[0];
      f3       <= f2;
    end
  end

  // Stage 4: pick the nearer of the lower note and the one above it. At or
  // below C0 both are C0; above B8 the upper note stays at B8.
  logic [3:0]         up_oct, up_semi;
  logic [PITCH_W-1:0] p_lo, p_up;
  logic [FREQ_W-1:0]  below, above;
  logic               take_up;
  logic [3:0]         oct4, semi4;
  logic [PITCH_W-1:0] p4;
  logic [FREQ_W-1:0]  f4;

  always_comb begin
    if (!found3) begin
      up_oct  = lo_oct3;
      up_semi = lo_semi3;
    end else if (lo_semi3 == 4'd11) begin
      if (lo_oct3 == 4'd8) begin
        up_oct  = lo_oct3;
        up_semi = lo_semi3;
      end else begin
        up_oct  = lo_oct3 + 4'd1;
        up_semi = 4'd0;
      end
    end else begin
      up_oct  = lo_oct3;
      up_semi = lo_semi3 + 4'd1;
    end
    p_lo    = pitch_of(lo_oct3, lo_semi3);
    p_up    = pitch_of(up_oct, up_semi);
    below   = f3 - {{(FREQ_W-PITCH_W){1'b0}}, p_lo};
    above   = {{(FREQ_W-PITCH_W){1'b0}}, p_up} - f3;
    take_up = ((up_oct != lo_oct3) || (up_semi != lo_semi3)) && (below > above);
  end

  always_ff @(posedge clk) begin
    if (go4) begin
      oct4  <= take_up ? up_oct : lo_oct3;
      semi4 <= take_up ? up_semi : lo_semi3;
      p4    <= take_up ? p_up : p_lo;
      f4    <= f3;
    end
  end

  // Stage 5: magnitude of the deviation times ten thousand, and its sign.
  logic [FREQ_W-1:0] p4_wide, dev_mag;
  logic              dev_neg;
  logic [NUM_W-1:0]  num5;
  side_t             side5;

  assign p4_wide = {{(FREQ_W-PITCH_W){1'b0}}, p4};
  assign dev_neg = f4 < p4_wide;
  assign dev_mag = dev_neg ? p4_wide - f4 : f4 - p4_wide;

  always_ff @(posedge clk) begin
    if (go5) begin
      num5         <= {{(NUM_W-FREQ_W){1'b0}}, dev_mag} * NUM_W'(10000);
      side5.scaled <= f4;
      side5.octave <= oct4;
      side5.semi   <= semi4;
      side5.pitch  <= p4;
      side5.neg    <= dev_neg;
      side5.sat    <= 1'b0;
    end
  end

  // Stage 6: a quotient of 32768 or more saturates; otherwise the product is
  // below pitch times 2^15 and fits the divider's remainder.
  logic [NUM_W-1:0] sat_limit;
  logic [REM_W-1:0] rem6;
  side_t            side6, side6_next;

  assign sat_limit = {{(NUM_W-REM_W){1'b0}}, side5.pitch, {QUOT_W{1'b0}}};

  always_comb begin
    side6_next     = side5;
    side6_next.sat = num5 >= sat_limit;
  end

  always_ff @(posedge clk) begin
    if (go6) begin
      rem6  <= num5[REM_W-1:0];
      side6 <= side6_next;
    end
  end

  // Divider: fifteen stages, one quotient bit each.
  side_t             div_side;
  logic [QUOT_W-1:0] div_quot;

  fnote_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v6),
    .up_stall (div_stall),
    .up_side  (side6),
    .up_rem   (rem6),
    .dn_valid (div_valid),
    .dn_stall (!go_out),
    .dn_side  (div_side),
    .dn_quot  (div_quot)
  );

  // Output stage: sign, saturation and deviation marks.
  logic [15:0]        mag;
  logic signed [15:0] mis;
  logic [1:0]         marks;

  always_comb begin
    mag = div_side.sat ? MIS_MAX : {1'b0, div_quot};
    mis = div_side.neg ? -$signed(mag) : $signed(mag);
    if (mag > {1'b0, level_three}) begin
      marks = 2'd3;
    end else if (mag > {1'b0, level_two}) begin
      marks = 2'd2;
    end else if (mag > {1'b0, level_one}) begin
      marks = 2'd1;
    end else begin
      marks = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_valid <= 1'b0;
    end else if (go_out) begin
      note_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out) begin
      note.scaled_frequency <= div_side.scaled;
      note.octave           <= div_side.octave;
      note.note_in_octave   <= div_side.semi;
      note.matched_pitch    <= div_side.pitch;
      note.mismatch         <= mis;
      note.sharp            <= !div_side.neg && (mag != 16'd0);
      note.mark_count       <= marks;
    end
  end

  // The reported pitch is the table pitch of the reported note.
  a_pitch_matches_note: assert property (@(posedge clk) disable iff (rst)
    note_valid |-> note.matched_pitch == pitch_of(note.octave, note.note_in_octave))
    else $error("matched pitch does not belong to the reported note");

  // Sharp is set exactly when the deviation is positive.
  a_sharp_sign: assert property (@(posedge clk) disable iff (rst)
    note_valid |-> note.sharp == (note.mismatch > 16'sd0))
    else $error("sharp flag disagrees with deviation sign");

  // A negative deviation means the frequency lies below the matched pitch.
  a_flat_below: assert property (@(posedge clk) disable iff (rst)
    (note_valid && note.mismatch < 16'sd0) |->
      note.scaled_frequency < {{(FREQ_W-PITCH_W){1'b0}}, note.matched_pitch})
    else $error("negative deviation above the matched pitch");

endmodule

// ----- src/fnote_div.sv -----
// ----------------------------------------------------------------------------
// fnote_div: pipelined restoring divider
// One quotient bit per stage, most significant first, with the side fields
// carried beside the remainder. Each stage holds its word until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnote_div import fnote_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_stall,
  input  side_t             up_side,
  input  logic [REM_W-1:0]  up_rem,
  output logic              dn_valid,
  input  logic              dn_stall,
  output side_t             dn_side,
  output logic [QUOT_W-1:0] dn_quot
);

  logic              v    [QUOT_W];
  logic [REM_W-1:0]  rem  [QUOT_W];
  logic [QUOT_W-1:0] quot [QUOT_W];
  side_t             side [QUOT_W];
  logic [QUOT_W:0]   go;

  always_comb begin
    go[QUOT_W] = !dn_stall;
    for (int k = QUOT_W - 1; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  assign up_stall = !go[0];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int B = QUOT_W - 1 - k;
    logic              src_v;
    logic [REM_W-1:0]  src_rem;
    logic [QUOT_W-1:0] src_quot;
    side_t             src_side;
    logic [REM_W-1:0]  dvs;
    logic              fit;

    if (k == 0) begin : g_first
      assign src_v    = up_valid;
      assign src_rem  = up_rem;
      assign src_quot = '0;
      assign src_side = up_side;
    end else begin : g_next
      assign src_v    = v[k-1];
      assign src_rem  = rem[k-1];
      assign src_quot = quot[k-1];
      assign src_side = side[k-1];
    end

    assign dvs = {{QUOT_W{1'b0}}, src_side.pitch} << B;
    assign fit = src_rem >= dvs;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (go[k+1] || !v[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (go[k+1] || !v[k]) begin
        rem[k]  <= fit ? src_rem - dvs : src_rem;
        quot[k] <= {src_quot[QUOT_W-2:0], fit};
        side[k] <= src_side;
      end
    end
  end

  assign dn_valid = v[QUOT_W-1];
  assign dn_side  = side[QUOT_W-1];
  assign dn_quot  = quot[QUOT_W-1];

endmodule

// ----- dv/tb_frequency_to_musical_note.sv -----
// ----------------------------------------------------------------------------
// tb_frequency_to_musical_note: self-checking bench for the note matcher
// Drives measurement words from a directed table and then at random, with
// random idling on both channels and one long output hold-off. Every result
// word is compared field by field with a hand-typed result or a behavioral
// note search in the bench; the three mark thresholds change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frequency_to_musical_note;
  import fnote_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   meas_valid;
  logic                   meas_stall;
  meas_word_t             meas;
  logic                   note_valid;
  logic                   note_stall;
  note_word_t             note;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]     cfg_data;

  frequency_to_musical_note dut (
    .clk(clk), .rst(rst),
    .meas_valid(meas_valid), .meas_stall(meas_stall), .meas(meas),
    .note_valid(note_valid), .note_stall(note_stall), .note(note),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int LATENCY = 22;

  // Bench copies of the threshold registers.
  logic [LEVEL_W-1:0] level_one, level_two, level_three;

  // Results still owed by the block, oldest first.
  note_word_t pending_notes[$];
  int         failures;

  // Idle rates in percent for each side; the hold-off flag freezes the output.
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_output;

  // Directed table: each row is a word plus an optional hand-typed result.
  typedef struct {
    meas_word_t word;
    bit         typed;
    note_word_t result;
  } meas_row_t;

  // Octave-8 pitches, one per semitone.
  function automatic longint top_octave_pitch(int semi);
    case (semi)
      0:  return 418601;
      1:  return 443492;
      2:  return 469864;
      3:  return 497803;
      4:  return 527404;
      5:  return 558765;
      6:  return 591991;
      7:  return 627193;
      8:  return 664488;
      9:  return 704000;
      10: return 745862;
      default: return 790213;
    endcase
  endfunction

  function automatic longint note_pitch(int n);
    return top_octave_pitch(n % SEMIS) >> (8 - n / SEMIS);
  endfunction

  // Finds the nearest note to a measurement and its deviation.
  function automatic note_word_t match_note(meas_word_t w);
    note_word_t r;
    longint f, p, mis, mag;
    int lower, upper, best;
    bit found;
    f = w.measured_frequency;
    if (w.tenths_mode) f = f * 10;
    lower = 0;
    found = 0;
    for (int n = 0; n < NOTES; n++) begin
      if (f > note_pitch(n)) begin
        lower = n;
        found = 1;
      end else begin
        break;
      end
    end
    upper = found ? lower + 1 : 0;
    if (upper > NOTES - 1) upper = NOTES - 1;
    best = lower;
    // A tie between the two neighbors goes to the lower note.
    if (upper != lower && (f - note_pitch(lower)) > (note_pitch(upper) - f)) best = upper;
    p = note_pitch(best);
    mis = ((f - p) * 10000) / p;
    if (mis > 32767) mis = 32767;
    mag = mis < 0 ? -mis : mis;
    r.scaled_frequency = f[FREQ_W-1:0];
    r.octave           = 4'(best / SEMIS);
    r.note_in_octave   = 4'(best % SEMIS);
    r.matched_pitch    = p[PITCH_W-1:0];
    r.mismatch         = mis[15:0];
    r.sharp            = mis > 0;
    // Thresholds are tried from the third down, whatever their order.
    if (mag > level_three)    r.mark_count = 2'd3;
    else if (mag > level_two) r.mark_count = 2'd2;
    else if (mag > level_one) r.mark_count = 2'd1;
    else                      r.mark_count = 2'd0;
    return r;
  endfunction

  function automatic note_word_t typed_note(int f, int oct, int semi, int p, int mis,
                                            int marks);
    note_word_t r;
    r.scaled_frequency = FREQ_W'(f);
    r.octave           = 4'(oct);
    r.note_in_octave   = 4'(semi);
    r.matched_pitch    = PITCH_W'(p);
    r.mismatch         = 16'(mis);
    r.sharp            = mis > 0;
    r.mark_count       = 2'(marks);
    return r;
  endfunction

  function automatic meas_row_t make_row(int f, bit tenths, bit typed = 0,
                                         note_word_t result = '0);
    meas_row_t row;
    row.word.measured_frequency = MEAS_W'(f);
    row.word.tenths_mode        = tenths;
    row.typed                   = typed;
    row.result                  = result;
    return row;
  endfunction

  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = 1'b1;
      #6 clk = 1'b0;
    end
  end

  // Result side: the stall is redrawn at each falling edge, and the word is
  // checked at the rising edge where it is taken.
  initial begin
    note_stall = 1'b0;
    forever begin
      @(negedge clk);
      note_stall <= hold_output || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    note_word_t want;
    if (!rst && note_valid && !note_stall) begin
      if (pending_notes.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, note);
        failures++;
      end else begin
        want = pending_notes.pop_front();
        if (note.scaled_frequency !== want.scaled_frequency)
          $display("%0t: scaled_frequency expected %0d actual %0d", $time,
                   want.scaled_frequency, note.scaled_frequency);
        if (note.octave !== want.octave)
          $display("%0t: octave expected %0d actual %0d", $time, want.octave, note.octave);
        if (note.note_in_octave !== want.note_in_octave)
          $display("%0t: note_in_octave expected %0d actual %0d", $time,
                   want.note_in_octave, note.note_in_octave);
        if (note.matched_pitch !== want.matched_pitch)
          $display("%0t: matched_pitch expected %0d actual %0d", $time,
                   want.matched_pitch, note.matched_pitch);
        if (note.mismatch !== want.mismatch)
          $display("%0t: mismatch expected %0d actual %0d", $time, want.mismatch,
                   note.mismatch);
        if (note.sharp !== want.sharp)
          $display("%0t: sharp expected %0b actual %0b", $time, want.sharp, note.sharp);
        if (note.mark_count !== want.mark_count)
          $display("%0t: mark_count expected %0d actual %0d", $time, want.mark_count,
                   note.mark_count);
        if (note !== want) failures++;
      end
    end
  end

  // Offers one measurement word, with a random idle gap in front, and holds
  // it until the block takes it. The expected result is queued on acceptance.
  // Valid stays high afterwards; the caller lowers it after the last word.
  task automatic send_meas(meas_word_t w, bit typed, note_word_t typed_result);
    while ($urandom_range(99) < send_idle_pct) begin
      meas_valid <= 1'b0;
      @(negedge clk);
    end
    meas_valid <= 1'b1;
    meas       <= w;
    do @(posedge clk); while (meas_stall);
    pending_notes.push_back(typed ? typed_result : match_note(w));
    @(negedge clk);
  endtask

  // Writes one threshold register; only called with nothing in flight.
  // Valid stays high for the next write; the caller lowers it at the end.
  task automatic write_level(cfg_index_t idx, logic [LEVEL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MARK_ONE:   level_one   = value;
      CFG_MARK_TWO:   level_two   = value;
      CFG_MARK_THREE: level_three = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_levels(int one, int two, int three);
    write_level(CFG_MARK_ONE, LEVEL_W'(one));
    write_level(CFG_MARK_TWO, LEVEL_W'(two));
    write_level(CFG_MARK_THREE, LEVEL_W'(three));
    cfg_valid <= 1'b0;
  endtask

  // Waits for every owed result, then lets the pipeline run dry.
  task automatic drain;
    meas_valid <= 1'b0;
    while (pending_notes.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Random measurement: mostly frequencies within the note range, scattered
  // around real notes, plus full-range noise in either mode.
  function automatic meas_word_t random_meas();
    meas_word_t w;
    int n, kind;
    longint p;
    kind = $urandom_range(9);
    w.tenths_mode = $urandom_range(1);
    if (kind < 6) begin
      n = $urandom_range(NOTES - 1);
      p = note_pitch(n);
      p = p + $signed($urandom_range(p / 8 + 2)) - p / 16 - 1;
      if (p < 0) p = 0;
      if (w.tenths_mode) p = p / 10;
      w.measured_frequency = MEAS_W'(p);
    end else if (kind < 8) begin
      w.measured_frequency = MEAS_W'($urandom_range(1000000));
    end else begin
      w.measured_frequency = MEAS_W'($urandom());
    end
    return w;
  endfunction

  initial begin
    meas_row_t table_rows[$];
    failures       = 0;
    hold_output    = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    rst            = 1'b1;
    meas_valid     = 1'b0;
    meas           = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_MARK_ONE;
    cfg_data       = '0;
    level_one      = LEVEL_ONE_RESET;
    level_two      = LEVEL_TWO_RESET;
    level_three    = LEVEL_THREE_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero sits below C0 (pitch 1635) and reads a full negative deviation.
    table_rows.push_back(make_row(0, 0, 1, typed_note(0, 0, 0, 1635, -10000, 3)));
    table_rows.push_back(make_row(0, 1, 1, typed_note(0, 0, 0, 1635, -10000, 3)));
    // Exactly on C0 and exactly on B8.
    table_rows.push_back(make_row(1635, 0, 1, typed_note(1635, 0, 0, 1635, 0, 0)));
    table_rows.push_back(make_row(790213, 0, 1, typed_note(790213, 8, 11, 790213, 0, 0)));
    // Top of the field: far above B8, saturated.
    table_rows.push_back(make_row(16777215, 0, 1,
                                  typed_note(16777215, 8, 11, 790213, 32767, 3)));
    table_rows.push_back(make_row(16777215, 1, 1,
                                  typed_note(167772150, 8, 11, 790213, 32767, 3)));
    // A4 in both modes, and a tie midway between A4 and A#4.
    table_rows.push_back(make_row(44000, 0));
    table_rows.push_back(make_row(4400, 1));
    table_rows.push_back(make_row((44000 + 46616) / 2, 0));
    table_rows.push_back(make_row((44000 + 46616) / 2 + 1, 0));
    // Just below C0, just above B8, and the gap from B7 to C8.
    table_rows.push_back(make_row(1634, 0));
    table_rows.push_back(make_row(790214, 0));
    table_rows.push_back(make_row(400000, 0));
    table_rows.push_back(make_row(409000, 0));
    table_rows.push_back(make_row(2000000, 0));
    table_rows.push_back(make_row(1, 0));
    table_rows.push_back(make_row(1, 1));
    table_rows.push_back(make_row(2, 0));
    table_rows.push_back(make_row(12345, 1));
    table_rows.push_back(make_row(24'haaaaaa, 0));
    table_rows.push_back(make_row(24'h555555, 1));
    foreach (table_rows[i]) send_meas(table_rows[i].word, table_rows[i].typed,
                                      table_rows[i].result);
    drain();

    // Phase one: sender idles lightly, receiver heavily; thresholds reversed.
    set_levels(32767, 0, 16384);
    send_idle_pct = 11;
    recv_idle_pct = 49;
    for (int i = 0; i < 170; i++) send_meas(random_meas(), 0, '0);
    drain();

    // Phase two: roles swapped; zero thresholds mark almost every word.
    set_levels(0, 0, 0);
    send_idle_pct = 49;
    recv_idle_pct = 11;
    for (int i = 0; i < 170; i++) send_meas(random_meas(), 0, '0);
    drain();

    // Phase three: full rate, with a long output hold-off while words keep
    // coming so that the pipeline fills and stalls its input.
    set_levels(25, 150, 32767);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_output = 1'b1;
        repeat (80) @(negedge clk);
        hold_output = 1'b0;
      end
      begin
        for (int i = 0; i < 160; i++) send_meas(random_meas(), 0, '0);
        meas_valid <= 1'b0;
      end
    join
    drain();

    if (failures == 0 && pending_notes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
